/* rtl/vad_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_pkg: shared types and constants for the vector angle unit
// Widths, the CORDIC arctangent table (degrees, Q24) and the pipeline payload.
// ----------------------------------------------------------------------------
package vad_pkg;

  // Field widths of the channels
  localparam int unsigned PORT_WIDTH  = 16;
  localparam int unsigned ANGLE_WIDTH = 17;

  // Datapath configuration
  localparam int unsigned COMPONENT_WIDTH = 16;
  localparam int unsigned CORDIC_STEPS    = 16;
  localparam int unsigned GUARD_BITS      = 24;
  localparam int unsigned TABLE_SIZE      = 32;
  localparam int unsigned NUM_STEPS       =
    (CORDIC_STEPS < TABLE_SIZE) ? CORDIC_STEPS : TABLE_SIZE;
  localparam int unsigned STEP_W          = $clog2(TABLE_SIZE);

  // X/Y registers: magnitude, guard bits, CORDIC growth and sign
  localparam int unsigned DP_WIDTH    = COMPONENT_WIDTH + GUARD_BITS + 3;
  localparam int unsigned Z_WIDTH     = 33;
  localparam int unsigned THETA_WIDTH = 15;
  localparam int unsigned ROUND_SHIFT = 16;

  localparam logic signed [Z_WIDTH-1:0] DEG90_Z    = 33'sd1509949440;
  localparam logic signed [Z_WIDTH-1:0] ROUND_HALF = 33'sd32768;

  localparam logic signed [ANGLE_WIDTH-1:0] DEG90_OUT  = 17'sd23040;
  localparam logic signed [ANGLE_WIDTH-1:0] DEG180_OUT = 17'sd46080;
  localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MIN  = -17'sd46079;

  // atan(2^-i) in degrees, scaled by 2^24
  localparam logic [31:0] ATAN_TABLE [TABLE_SIZE] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115,
    32'd57,        32'd29,        32'd14,        32'd7,
    32'd4,         32'd2,         32'd1,         32'd0
  };

  // Quadrant and special-case information carried alongside the rotation
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
  } vad_flags_t;

  typedef struct packed {
    logic signed [DP_WIDTH-1:0] xr;
    logic signed [DP_WIDTH-1:0] yr;
    logic signed [Z_WIDTH-1:0]  z;
    vad_flags_t                 flags;
  } vad_cordic_t;

endpackage

/* rtl/vad_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_if: valid/ready channels of the vector angle unit
// One interface for the vector input and one for the angle result.
// ----------------------------------------------------------------------------
interface vad_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [vad_pkg::PORT_WIDTH-1:0]   x_value;
  logic signed [vad_pkg::PORT_WIDTH-1:0]   y_value;

  modport source (output valid, output x_value, output y_value, input ready);
  modport sink   (input valid, input x_value, input y_value, output ready);
endinterface

interface vad_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [vad_pkg::ANGLE_WIDTH-1:0]  angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

/* rtl/vad_cordic_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_cordic_stage: one registered vectoring-mode CORDIC iteration
// Rotates (X, Y) towards the X axis by atan(2^-step) and accumulates the angle.
// ----------------------------------------------------------------------------
module vad_cordic_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [vad_pkg::STEP_W-1:0]    step_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  vad_pkg::vad_cordic_t          data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output vad_pkg::vad_cordic_t          data_o
);

  logic                                   valid_q;
  vad_pkg::vad_cordic_t                   data_q;
  vad_pkg::vad_cordic_t                   data_d;
  logic signed [vad_pkg::DP_WIDTH-1:0]    xs;
  logic signed [vad_pkg::DP_WIDTH-1:0]    ys;
  logic signed [vad_pkg::Z_WIDTH-1:0]     atan_z;

  // Stage takes a transfer when empty or when its content moves on
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Micro-rotation; X stays non-negative, Y shift is a floor shift
  always_comb begin
    xs     = data_i.xr >>> step_i;
    ys     = data_i.yr >>> step_i;
    atan_z = signed'({1'b0, vad_pkg::ATAN_TABLE[step_i]});
    data_d = data_i;
    if (!data_i.yr[vad_pkg::DP_WIDTH-1]) begin
      data_d.xr = data_i.xr + ys;
      data_d.yr = data_i.yr - xs;
      data_d.z  = data_i.z + atan_z;
    end else begin
      data_d.xr = data_i.xr - ys;
      data_d.yr = data_i.yr + xs;
      data_d.z  = data_i.z - atan_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* rtl/vector_angle_degrees.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angle_degrees: angle of a signed 2-D vector in 1/256 degree
// Pipelined CORDIC arctangent with quadrant mirroring and axis special cases.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries a vector (x_value, y_value), two's complement integers.
//   out_o carries angle, signed, 1/256 degree, -180 exclusive to +180
//   inclusive. Every input transfer gives exactly one result, in order.
// Pipeline: one entry register, one register per CORDIC iteration, a
//   clamp/round register and the output register lie between an input
//   transfer and out_o.valid.
// Throughput: one vector per clock while out_o accepts results. Each
//   iteration has its own adder stage, so a new vector can enter every cycle.
// Stalls: each stage holds its content while the next one is full and
//   stalled. Bubbles still fill, so in_i stays ready while empty stages
//   remain, even with a result waiting on out_o.
// Reset: all valid bits clear, the pipeline empties and in_i is ready.
// ----------------------------------------------------------------------------
module vector_angle_degrees (
  input  logic      clk_i,
  input  logic      rst_ni,
  vad_in_if.sink    in_i,
  vad_out_if.source out_o
);

  localparam int unsigned CW = vad_pkg::COMPONENT_WIDTH;
  localparam int unsigned PW = vad_pkg::PORT_WIDTH;
  localparam int unsigned NS = vad_pkg::NUM_STEPS;
  localparam int unsigned AW = vad_pkg::ANGLE_WIDTH;
  localparam int unsigned TW = vad_pkg::THETA_WIDTH;

  logic [CW-1:0]          x_raw;
  logic [CW-1:0]          y_raw;
  logic [CW-1:0]          x_mag;
  logic [CW-1:0]          y_mag;
  vad_pkg::vad_cordic_t   entry_d;

  logic                   s0_valid_q;
  vad_pkg::vad_cordic_t   s0_data_q;

  vad_pkg::vad_cordic_t   st_data  [NS+1];
  logic                   st_valid [NS+1];
  logic                   st_ready [NS+1];

  logic                             fa_valid_q;
  logic                             fa_ready;
  logic [TW-1:0]                    fa_theta_q;
  vad_pkg::vad_flags_t              fa_flags_q;
  logic signed [vad_pkg::Z_WIDTH-1:0] z_clamp;
  logic signed [vad_pkg::Z_WIDTH-1:0] z_round;
  logic [TW-1:0]                    theta_d;

  logic                   fb_valid_q;
  logic                   fb_ready;
  logic signed [AW-1:0]   angle_q;
  logic signed [AW-1:0]   angle_d;
  logic signed [AW-1:0]   mirrored;

  // Low COMPONENT_WIDTH bits of each component, or the component zero-extended to COMPONENT_WIDTH
  if (CW <= PW) begin : g_trunc
    assign x_raw = in_i.x_value[CW-1:0];
    assign y_raw = in_i.y_value[CW-1:0];
  end else begin : g_widen
    assign x_raw = {{(CW-PW){1'b0}}, in_i.x_value};
    assign y_raw = {{(CW-PW){1'b0}}, in_i.y_value};
  end

  // Entry: magnitudes scaled by the guard bits, quadrant flags
  always_comb begin
    x_mag                 = x_raw[CW-1] ? (~x_raw + 1'b1) : x_raw;
    y_mag                 = y_raw[CW-1] ? (~y_raw + 1'b1) : y_raw;
    entry_d.xr            = signed'({{(vad_pkg::DP_WIDTH-CW){1'b0}}, x_mag}
                                    << vad_pkg::GUARD_BITS);
    entry_d.yr            = signed'({{(vad_pkg::DP_WIDTH-CW){1'b0}}, y_mag}
                                    << vad_pkg::GUARD_BITS);
    entry_d.z             = '0;
    entry_d.flags.x_zero  = (x_raw == '0);
    entry_d.flags.y_zero  = (y_raw == '0);
    entry_d.flags.x_neg   = x_raw[CW-1];
    entry_d.flags.y_neg   = y_raw[CW-1];
  end

  assign in_i.ready = !s0_valid_q || st_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s0_data_q <= entry_d;
    end
  end

  // CORDIC iterations, one register stage each
  assign st_data[0]  = s0_data_q;
  assign st_valid[0] = s0_valid_q;

  for (genvar k = 0; k < NS; k++) begin : g_step
    vad_cordic_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (vad_pkg::STEP_W'(k)),
      .valid_i (st_valid[k]),
      .ready_o (st_ready[k]),
      .data_i  (st_data[k]),
      .valid_o (st_valid[k+1]),
      .ready_i (st_ready[k+1]),
      .data_o  (st_data[k+1])
    );
  end

  assign st_ready[NS] = fa_ready;

  // Clamp to 0..90 degrees and round to 1/256 degree
  always_comb begin
    if (st_data[NS].z[vad_pkg::Z_WIDTH-1]) begin
      z_clamp = '0;
    end else if (st_data[NS].z > vad_pkg::DEG90_Z) begin
      z_clamp = vad_pkg::DEG90_Z;
    end else begin
      z_clamp = st_data[NS].z;
    end
    z_round = z_clamp + vad_pkg::ROUND_HALF;
    // on the X axis the angle is exactly zero
    theta_d = st_data[NS].flags.y_zero ? '0 : z_round[vad_pkg::ROUND_SHIFT +: TW];
  end

  assign fa_ready = !fa_valid_q || fb_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_valid_q <= 1'b0;
    end else if (fa_ready) begin
      fa_valid_q <= st_valid[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fa_ready && st_valid[NS]) begin
      fa_theta_q <= theta_d;
      fa_flags_q <= st_data[NS].flags;
    end
  end

  // Quadrant mapping, Y axis cases, minus 180 folded to plus 180
  always_comb begin
    mirrored = fa_flags_q.x_neg
             ? (vad_pkg::DEG180_OUT - signed'({{(AW-TW){1'b0}}, fa_theta_q}))
             : signed'({{(AW-TW){1'b0}}, fa_theta_q});
    if (fa_flags_q.x_zero) begin
      if (fa_flags_q.y_zero) begin
        angle_d = '0;
      end else if (fa_flags_q.y_neg) begin
        angle_d = -vad_pkg::DEG90_OUT;
      end else begin
        angle_d = vad_pkg::DEG90_OUT;
      end
    end else begin
      angle_d = fa_flags_q.y_neg ? -mirrored : mirrored;
    end
    if (angle_d == -vad_pkg::DEG180_OUT) begin
      angle_d = vad_pkg::DEG180_OUT;
    end
  end

  // Output register
  assign fb_ready    = !fb_valid_q || out_o.ready;
  assign out_o.valid = fb_valid_q;
  assign out_o.angle = angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_valid_q <= 1'b0;
    end else if (fb_ready) begin
      fb_valid_q <= fa_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fb_ready && fa_valid_q) begin
      angle_q <= angle_d;
    end
  end

endmodule

/* rtl/vad_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_checker: port-level checks for the vector angle unit
// Watches the channels of the top level; attached by the bind below.
// ----------------------------------------------------------------------------
module vad_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_ready_i,
  input logic                                   out_valid_i,
  input logic                                   out_ready_i,
  input logic signed [vad_pkg::ANGLE_WIDTH-1:0] angle_i
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(angle_i))
    else $error("result changed while stalled");

  // Angles stay in the half-open range (-180, +180]
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (angle_i >= vad_pkg::ANGLE_MIN) && (angle_i <= vad_pkg::DEG180_OUT))
    else $error("angle out of range");

  // An empty output register means the pipeline can take a vector
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with output register empty");

  // Nothing is offered while reset is applied
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

endmodule

bind vector_angle_degrees vad_checker u_vad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .angle_i     (out_o.angle)
);
